// File: rtl/core/swbo_pkg.sv
`default_nettype none

package swbo_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned WINDOW_DEFAULT       = 10;
  localparam int unsigned SAMPLE_WIDTH_DEFAULT = 16;

  // Fixed field widths
  localparam int unsigned POS_W       = 32;
  localparam int unsigned K_W         = 3;
  localparam int unsigned OUT_FIELD_W = 2 + POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam logic [0:0]  REG_BAND_MULT = 1'b0;
  localparam logic [K_W-1:0] BAND_MULT_RESET = 3'd2;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_x;    // latch the accepted sample
    logic rd_old;    // read the slot about to be overwritten
    logic upd;       // update ring, sum, fill count and position
    logic issue;     // push one element into the square pipeline
    logic scale;     // form both sides of the compare
    logic cmp;       // take the decision
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fill_to_full;  // window is full once this update lands
    logic last_issue;    // current issue is the deviation term
    logic pipe_busy;     // square pipeline still holds elements
    logic out_busy;      // output register holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sliding_window_band_outlier.sv
// Bollinger-band outlier detector over a sliding window of WINDOW samples.
// Input stream (s_axis_*): one signed sample per request in tdata.
// Output stream (m_axis_*): one result per sample: window_full, is_outlier
// and the saturating 1-based position of the sample.
// APB port: register 0 (byte address 0) holds band_multiplier k (3 bits,
// reset 2); pready is always high and reads return the register value.
// Write it only while no sample is in flight.
// Sequence: a sample is taken in the idle state. Before the window is full
// it passes through the read-old and update states and its result is
// loaded in the output state; in the cycle after that load the controller
// is idle again. With a full window the ring is swept through one shared
// squaring multiplier: WINDOW + 1 issues, a drain of the 3-stage pipeline,
// scale and compare, and then the result is loaded. A new sample is taken
// only after the last result is loaded; the single read port of the ring
// memory and the shared multiplier set this.
// Reset clears the fill count, running sum, position and all handshake
// state; ring contents are left as they are, since entries are used only
// after being written. When the receiver stalls, the result holds in the
// output register; one more sample is processed and then waits for it.
`default_nettype none

module sliding_window_band_outlier #(
  parameter int unsigned WINDOW       = swbo_pkg::WINDOW_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = swbo_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // APB configuration
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [swbo_pkg::PADDR_W-1:0]             paddr,
  input  wire logic [swbo_pkg::APB_DATA_W-1:0]          pwdata,
  output logic      [swbo_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                          pready,
  // Sample stream
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // tdata: sample
  input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0]  s_axis_tdata,
  // Result stream
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // tdata: window_full, is_outlier, position[31:0]
  output logic      [swbo_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  import swbo_pkg::*;

  logic [K_W-1:0] band_mult_q;
  logic           cfg_wr;
  logic           cfg_hit;
  cmd_t           cmd;
  sts_t           sts;

  // Register index is the byte address divided by four
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_BAND_MULT);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DATA_W'(band_mult_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_mult_q <= BAND_MULT_RESET;
    end else if (cfg_wr && cfg_hit) begin
      band_mult_q <= pwdata[K_W-1:0];
    end
  end

  // Sequence each request: update the ring, then with a full window sweep, scale and compare, then deliver
  swbo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring memory, running sum, squaring pipeline and output register
  swbo_dp #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .band_mult_i (band_mult_q),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/swbo_ram.sv
`default_nettype none

module swbo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/swbo_ctrl.sv
`default_nettype none

module swbo_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire swbo_pkg::sts_t sts_i,
  output swbo_pkg::cmd_t     cmd_o
);

  import swbo_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOLD = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          state_d      = S_RDOLD;
        end
      end
      S_RDOLD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.fill_to_full ? S_SWEEP : S_OUT;
      end
      S_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swbo_dp.sv
`default_nettype none

module swbo_dp #(
  parameter int unsigned WINDOW       = swbo_pkg::WINDOW_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = swbo_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire swbo_pkg::cmd_t                   cmd_i,
  output swbo_pkg::sts_t                        sts_o,
  input  wire logic [swbo_pkg::K_W-1:0]         band_mult_i,
  input  wire logic [SAMPLE_WIDTH-1:0]          sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [swbo_pkg::OUT_TDATA_W-1:0] out_data_o
);

  import swbo_pkg::*;

  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned FW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = SAMPLE_WIDTH + $clog2(WINDOW);
  localparam int unsigned DW   = SUMW + 1;
  localparam int unsigned MW   = SUMW;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned ACW  = SQW + $clog2(WINDOW);
  localparam int unsigned KSW  = 2 * K_W;
  localparam int unsigned RHW  = ACW + KSW;

  localparam logic signed [DW-1:0] NS       = DW'(WINDOW);
  localparam logic [FW-1:0]        FILL_MAX = FW'(WINDOW);
  localparam logic [FW-1:0]        FILL_PRE = FW'(WINDOW - 1);
  localparam logic [AW-1:0]        SLOT_MAX = AW'(WINDOW - 1);
  localparam logic [RHW-1:0]       NM1      = RHW'(WINDOW - 1);

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic [FW-1:0]                  fill_q;
  logic [AW-1:0]                  wslot_q;
  logic signed [SUMW-1:0]         sum_q;
  logic [POS_W-1:0]               pos_q;
  logic [FW-1:0]                  cnt_q;
  logic                           p1_q, p2_q, p3_q;
  logic                           d1_q, d2_q, d3_q;
  logic [MW-1:0]                  mag_q;
  logic [SQW-1:0]                 sq_q;
  logic [ACW-1:0]                 acc_q;
  logic [SQW-1:0]                 dsq_q;
  logic [KSW-1:0]                 k2_q;
  logic [RHW-1:0]                 lhs_q, rhs_q;
  logic                           full_q, outl_q;
  logic                           oval_q;
  logic [OUT_FIELD_W-1:0]         odata_q;

  logic [SAMPLE_WIDTH-1:0]        ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] old_s;
  logic                           win_full;
  logic                           last_issue;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic signed [SUMW-1:0]         old_term;
  logic signed [DW-1:0]           v_mem, v_dev, v_sel, v_abs;

  assign win_full   = (fill_q == FILL_MAX);
  assign last_issue = (cnt_q == FILL_MAX);
  assign ram_re     = cmd_i.rd_old | (cmd_i.issue & ~last_issue);
  assign ram_raddr  = cmd_i.rd_old ? wslot_q : cnt_q[AW-1:0];
  assign old_s      = $signed(ram_rdata);
  assign old_term   = win_full ? SUMW'(old_s) : '0;

  swbo_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (wslot_q),
    .wdata_i (x_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Element deviation (sum - N*x_j) or sample deviation (N*x - sum)
  always_comb begin
    v_mem = DW'(sum_q) - DW'(old_s) * NS;
    v_dev = DW'(x_q) * NS - DW'(sum_q);
    v_sel = d1_q ? v_dev : v_mem;
    v_abs = v_sel[DW-1] ? -v_sel : v_sel;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= $signed(sample_i);
    end
    mag_q <= MW'(v_abs);
    sq_q  <= SQW'(mag_q) * SQW'(mag_q);
    k2_q  <= KSW'(band_mult_i) * KSW'(band_mult_i);
    if (cmd_i.upd) begin
      acc_q <= '0;
    end else if (p3_q && !d3_q) begin
      acc_q <= acc_q + ACW'(sq_q);
    end
    if (p3_q && d3_q) begin
      dsq_q <= sq_q;
    end
    if (cmd_i.scale) begin
      lhs_q <= RHW'(dsq_q) * NM1;
      rhs_q <= RHW'(acc_q) * RHW'(k2_q);
    end
    if (cmd_i.upd) begin
      full_q <= win_full | (fill_q == FILL_PRE);
      outl_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      outl_q <= (lhs_q > rhs_q);
    end
    if (cmd_i.out_load) begin
      odata_q <= {pos_q, outl_q, full_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      wslot_q <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      p3_q    <= 1'b0;
      d1_q    <= 1'b0;
      d2_q    <= 1'b0;
      d3_q    <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        sum_q   <= sum_q - old_term + SUMW'(x_q);
        wslot_q <= (wslot_q == SLOT_MAX) ? '0 : wslot_q + 1'b1;
        if (!win_full) begin
          fill_q <= fill_q + 1'b1;
        end
        if (pos_q != POS_MAX) begin
          pos_q <= pos_q + 1'b1;
        end
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      p1_q <= cmd_i.issue;
      d1_q <= cmd_i.issue & last_issue;
      p2_q <= p1_q;
      d2_q <= d1_q;
      p3_q <= p2_q;
      d3_q <= d2_q;
      if (cmd_i.out_load) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  assign sts_o.fill_to_full = win_full | (fill_q == FILL_PRE);
  assign sts_o.last_issue   = last_issue;
  assign sts_o.pipe_busy    = p1_q | p2_q | p3_q;
  assign sts_o.out_busy     = oval_q & ~out_ready_i;

  assign out_valid_o = oval_q;
  assign out_data_o  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, odata_q};

endmodule

`default_nettype wire
